// ===== rtl/sepq_pkg.sv =====
// shared constants, codes and control structs for the sorted event priority queue
// no dependencies; used by the controller, the datapath and the top level
package sepq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the input beat
        logic exec;     // run the queue update or the handle compare
        logic finish;   // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a new beat this cycle
    } t_sts;

endpackage

// ===== rtl/sepq_ctrl.sv =====
// sequencing controller for the sorted event priority queue
// depends on sepq_pkg (t_cmd, t_sts)
module sepq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sepq_pkg::t_sts  i_sts,
    output sepq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall        = r_stall;
    assign o_cmd.capture  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.finish   = (r_state == S_FIN) && i_sts.out_free;

    // input is held off exactly while an item is in flight
    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (r_state != S_IDLE))
        else $error("stall out of step with state");

    // an accepted beat always reaches the execute step next
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("captured beat not executed");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.exec, o_cmd.finish}))
        else $error("overlapping commands");

endmodule

// ===== rtl/sepq_dp.sv =====
// sorted slot array, handle compare and output register of the priority queue
// depends on sepq_pkg (sizes, codes, t_cmd, t_sts)
module sepq_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sepq_pkg::t_cmd                         i_cmd,
    output sepq_pkg::t_sts                         o_sts,
    input  logic [1:0]                             i_action,
    input  logic signed [sepq_pkg::KEY_BITS-1:0]   i_entry_key,
    input  logic [sepq_pkg::HANDLE_BITS-1:0]       i_entry_handle,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_status,
    output logic signed [sepq_pkg::KEY_BITS-1:0]   o_popped_key,
    output logic [sepq_pkg::HANDLE_BITS-1:0]       o_popped_handle,
    output logic                                   o_found,
    output logic                                   o_not_empty
);

    localparam int D  = sepq_pkg::QUEUE_DEPTH;
    localparam int KB = sepq_pkg::KEY_BITS;
    localparam int HB = sepq_pkg::HANDLE_BITS;

    // captured beat
    logic [1:0]           r_action;
    logic signed [KB-1:0] r_key;
    logic [HB-1:0]        r_handle;

    // sorted slots, valid bits form a prefix
    logic signed [KB-1:0] r_keys [D];
    logic [HB-1:0]        r_handles [D];
    logic [D-1:0]         r_valid, n_valid;
    logic signed [KB-1:0] n_keys [D];
    logic [HB-1:0]        n_handles [D];

    // per-slot handle matches, reduced in the finish step
    logic [D-1:0]         r_match;

    // result staged between execute and finish
    logic [1:0]           r_res_status;
    logic signed [KB-1:0] r_res_key;
    logic [HB-1:0]        r_res_handle;

    // output register
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic signed [KB-1:0] r_out_key;
    logic [HB-1:0]        r_out_handle;
    logic                 r_out_found;
    logic                 r_out_not_empty;

    logic [D-1:0]         le;
    logic                 full;
    logic                 empty;

    assign full  = r_valid[D-1];
    assign empty = !r_valid[0];

    // slot keeps its place when its key is at or below the new key
    always_comb begin
        for (int i = 0; i < D; i++) begin
            le[i] = r_valid[i] && (r_keys[i] <= r_key);
        end
    end

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < D; i++) begin
            n_keys[i]    = r_keys[i];
            n_handles[i] = r_handles[i];
        end
        case (r_action)
            sepq_pkg::ACT_INSERT: begin
                if (!full) begin
                    if (!le[0]) begin
                        n_keys[0]    = r_key;
                        n_handles[0] = r_handle;
                    end
                    for (int i = 1; i < D; i++) begin
                        if (!le[i]) begin
                            if (le[i-1]) begin
                                n_keys[i]    = r_key;
                                n_handles[i] = r_handle;
                            end else begin
                                n_keys[i]    = r_keys[i-1];
                                n_handles[i] = r_handles[i-1];
                            end
                        end
                    end
                    n_valid = {r_valid[D-2:0], 1'b1};
                end
            end
            sepq_pkg::ACT_POP: begin
                if (!empty) begin
                    for (int i = 0; i < D - 1; i++) begin
                        n_keys[i]    = r_keys[i+1];
                        n_handles[i] = r_handles[i+1];
                    end
                    n_valid = {1'b0, r_valid[D-1:1]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_key    <= i_entry_key;
            r_handle <= i_entry_handle;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < D; i++) begin
                r_keys[i]    <= n_keys[i];
                r_handles[i] <= n_handles[i];
                r_match[i]   <= r_valid[i] && (r_handles[i] == r_handle);
            end
            if (r_action == sepq_pkg::ACT_INSERT && full) begin
                r_res_status <= sepq_pkg::ST_FULL;
            end else if (r_action == sepq_pkg::ACT_POP && empty) begin
                r_res_status <= sepq_pkg::ST_EMPTY;
            end else begin
                r_res_status <= sepq_pkg::ST_OK;
            end
            if (r_action == sepq_pkg::ACT_POP && !empty) begin
                r_res_key    <= r_keys[0];
                r_res_handle <= r_handles[0];
            end else begin
                r_res_key    <= '0;
                r_res_handle <= '0;
            end
        end
        if (i_cmd.finish) begin
            r_out_status    <= r_res_status;
            r_out_key       <= r_res_key;
            r_out_handle    <= r_res_handle;
            r_out_found     <= (r_action == sepq_pkg::ACT_QUERY) && (|r_match);
            r_out_not_empty <= r_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_valid <= n_valid;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_stall;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_popped_key    = r_out_key;
    assign o_popped_handle = r_out_handle;
    assign o_found         = r_out_found;
    assign o_not_empty     = r_out_not_empty;

    // occupied slots stay a prefix
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid >> 1) & ~r_valid) == '0)
        else $error("valid slots not a prefix");

    // occupancy moves by at most one per step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> ($countones(r_valid) <= $countones($past(r_valid)) + 1) &&
                       ($countones(r_valid) + 1 >= $countones($past(r_valid))))
        else $error("occupancy jumped");

    // a query never changes the queue
    a_query_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_action == sepq_pkg::ACT_QUERY) |=> $stable(r_valid))
        else $error("query changed occupancy");

    // finished results show up on the output
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_valid)
        else $error("finished result not presented");

endmodule

// ===== rtl/sorted_event_priority_queue_top.sv =====
// top level of the sorted event priority queue: controller plus slot datapath
// depends on sepq_pkg, sepq_ctrl and sepq_dp
// flow: an input beat is captured, then executed, then loaded into the output register
// in the finish step, which waits while the output is stalled; one item at a time
// the output register lets a new item enter while the previous result still waits
// reset: synchronous active-low i_rst_n empties the queue at once, no clearing pass
module sorted_event_priority_queue_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_action,
    input  logic signed [sepq_pkg::KEY_BITS-1:0]   i_entry_key,
    input  logic [sepq_pkg::HANDLE_BITS-1:0]       i_entry_handle,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_status,
    output logic signed [sepq_pkg::KEY_BITS-1:0]   o_popped_key,
    output logic [sepq_pkg::HANDLE_BITS-1:0]       o_popped_handle,
    output logic                                   o_found,
    output logic                                   o_not_empty
);

    // command and status between controller and datapath
    sepq_pkg::t_cmd cmd;
    sepq_pkg::t_sts sts;

    // controller: idle, execute, finish sequence; drives input stall
    sepq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: sorted slots shift in parallel on insert and pop,
    // handle matches registered per slot and or-reduced in the finish step
    sepq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_entry_key     (i_entry_key),
        .i_entry_handle  (i_entry_handle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_popped_key    (o_popped_key),
        .o_popped_handle (o_popped_handle),
        .o_found         (o_found),
        .o_not_empty     (o_not_empty)
    );

endmodule
